[hdl/mted_pkg.sv]
// ============================================================================
// mted_pkg: shared types and constants of the multi-tap echo delay
// Holds the transaction payload structs, the sequencer states, the
// configuration register indexes and the Q1.15 gain helpers.
// ============================================================================
`default_nettype none

package mted_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int DELAY_W    = 16;
    localparam int TAPS_W     = 5;
    localparam int TOTAL_W    = DELAY_W + TAPS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Q1.15 unity and the rounding half used after each Q15 product.
    localparam logic [GAIN_W-1:0] Q15_ONE  = 16'h8000;
    localparam logic [31:0]       Q15_HALF = 32'd16384;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY      = 3'd4;

    // Register values after reset.
    localparam logic [DELAY_W-1:0] RST_DELAY    = 16'd0;
    localparam logic [TAPS_W-1:0]  RST_TAPS     = 5'd1;
    localparam logic [GAIN_W-1:0]  RST_FEEDBACK = 16'd16384;
    localparam logic [GAIN_W-1:0]  RST_WET      = 16'd32768;
    localparam logic [GAIN_W-1:0]  RST_DRY      = 16'd32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       is_tail;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       tail_done;
    } mix_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_TAPS,
        ST_DRAIN,
        ST_FIN
    } state_t;

    // Gains above unity act as unity.
    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
        return (g > Q15_ONE) ? Q15_ONE : g;
    endfunction

endpackage

`default_nettype wire

[hdl/mted_ram.sv]
// ============================================================================
// mted_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ============================================================================
`default_nettype none

module mted_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/multi_tap_echo_delay_core.sv]
// ============================================================================
// multi_tap_echo_delay_core: multi-tap echo with a shared history memory
// Mixes each sample with up to MAX_TAPS decaying echoes read from a
// history RAM through a single pipelined multiply-accumulate datapath.
// ============================================================================
// Usage notes.
// The sample channel (sample_valid, sample_ready, sample_data) carries one
// PCM sample per transaction; a tail transaction stands for silence and
// flushes the echoes. The mix channel (mix_valid, mix_ready, mix_data)
// returns exactly one mixed sample per sample transaction, in order.
// Registers are to be written through cfg_we, cfg_index and cfg_data only
// while the block is idle; the block itself does not enforce this. A write
// takes effect at once. An accepted transaction passes through a preparation
// state, the tap and drain states (both skipped with no taps) and a finish
// state that loads the output register; only then is the next sample
// accepted. The history RAM has one read port and the taps are read one per
// cycle, followed by a three-stage coefficient, product and accumulate
// pipeline.
// The result sits in an output register, so sample_ready returns while a
// finished result still waits on a stalled receiver; the following result
// holds in the datapath until the receiver takes the first one.
// Reset clears the pointers and registers at once. The history RAM is not
// swept: a wrap flag and the write pointer tell which entries were written,
// and entries never written read as silence, so there is no clearing pass.
// ============================================================================
`default_nettype none

module multi_tap_echo_delay_core #(
    parameter int HISTORY_DEPTH = 2097152,
    parameter int MAX_TAPS      = 20
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output logic                                     sample_ready,
    input  wire mted_pkg::sample_t                   sample_data,
    output logic                                     mix_valid,
    input  wire logic                                mix_ready,
    output mted_pkg::mix_t                           mix_data,
    input  wire logic                                cfg_we,
    input  wire logic [mted_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mted_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // History address width and a few constants derived from the depth.
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [31:0] DEPTH_L = 32'(HISTORY_DEPTH);
    localparam logic [AW:0] DEPTH_AW1 = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);
    // Number of conditional subtract steps that reduce a 16-bit delay
    // modulo the depth.
    localparam int RED_STEPS = (HISTORY_DEPTH >= 65536) ? 1
                             : $clog2(65536 / HISTORY_DEPTH) + 1;
    localparam logic [mted_pkg::TAPS_W-1:0] TAPS_MAX_C = mted_pkg::TAPS_W'(MAX_TAPS);
    // Accumulator: dry term plus up to MAX_TAPS echo terms, each within 2^30.
    localparam int ACC_W = 32 + $clog2(MAX_TAPS + 2);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Delay reduced modulo the history depth by shifted compare-subtract.
    function automatic logic [AW-1:0] reduce_delay(input logic [15:0] d);
        logic [31:0] r;
        r = {16'b0, d};
        for (int s = RED_STEPS - 1; s >= 0; s--)
        begin
            if (((DEPTH_L << s) <= 32'd65535) && (r >= (DEPTH_L << s)))
            begin
                r = r - (DEPTH_L << s);
            end
        end
        return r[AW-1:0];
    endfunction

    // One delay further back in the circular history.
    function automatic logic [AW-1:0] step_back(input logic [AW-1:0] a,
                                                input logic [AW-1:0] b);
        logic [AW:0] t;
        if (a >= b)
        begin
            t = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            t = {1'b0, a} + DEPTH_AW1 - {1'b0, b};
        end
        return t[AW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [mted_pkg::DELAY_W-1:0] delay_reg;
    logic [mted_pkg::TAPS_W-1:0]  taps_reg;
    logic [mted_pkg::GAIN_W-1:0]  fb_reg;
    logic [mted_pkg::GAIN_W-1:0]  wet_reg;
    logic [mted_pkg::GAIN_W-1:0]  dry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= mted_pkg::RST_DELAY;
            taps_reg  <= mted_pkg::RST_TAPS;
            fb_reg    <= mted_pkg::RST_FEEDBACK;
            wet_reg   <= mted_pkg::RST_WET;
            dry_reg   <= mted_pkg::RST_DRY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mted_pkg::CFG_DELAY:    delay_reg <= cfg_data;
                mted_pkg::CFG_TAPS:     taps_reg  <= cfg_data[mted_pkg::TAPS_W-1:0];
                mted_pkg::CFG_FEEDBACK: fb_reg    <= cfg_data;
                mted_pkg::CFG_WET:      wet_reg   <= cfg_data;
                mted_pkg::CFG_DRY:      dry_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective settings: gains clamp at unity, taps clamp at MAX_TAPS.
    logic [mted_pkg::GAIN_W-1:0] fb_eff;
    logic [mted_pkg::GAIN_W-1:0] wet_eff;
    logic [mted_pkg::GAIN_W-1:0] dry_eff;
    logic [mted_pkg::TAPS_W-1:0] taps_eff;

    assign fb_eff   = mted_pkg::clamp_gain(fb_reg);
    assign wet_eff  = mted_pkg::clamp_gain(wet_reg);
    assign dry_eff  = mted_pkg::clamp_gain(dry_reg);
    assign taps_eff = (int'(taps_reg) > MAX_TAPS) ? TAPS_MAX_C : taps_reg;

    // The reduced tap spacing is registered and follows the delay register in
    // the next cycle; it is first used in the tap phase, well after any write.
    logic [AW-1:0] dmod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dmod_reg <= '0;
        end
        else
        begin
            dmod_reg <= reduce_delay(delay_reg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    mted_pkg::state_t state_reg;
    mted_pkg::state_t state_next;

    logic [mted_pkg::TAPS_W-1:0] tap_left_reg;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic mix_valid_reg;

    logic sample_ready_c;
    logic prep_go;
    logic tap_go;
    logic fin_go;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mted_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = mted_pkg::ST_PREP;
                end
            end
            mted_pkg::ST_PREP:
            begin
                state_next = (taps_eff == '0) ? mted_pkg::ST_FIN : mted_pkg::ST_TAPS;
            end
            mted_pkg::ST_TAPS:
            begin
                if (tap_left_reg == mted_pkg::TAPS_W'(1))
                begin
                    state_next = mted_pkg::ST_DRAIN;
                end
            end
            mted_pkg::ST_DRAIN:
            begin
                // The last product accumulates in this cycle once only the
                // final stage is busy.
                if (!v1_reg && !v2_reg)
                begin
                    state_next = mted_pkg::ST_FIN;
                end
            end
            mted_pkg::ST_FIN:
            begin
                if (!mix_valid_reg || mix_ready)
                begin
                    state_next = mted_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mted_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sample_ready_c = 1'b0;
        prep_go        = 1'b0;
        tap_go         = 1'b0;
        fin_go         = 1'b0;
        case (state_reg)
            mted_pkg::ST_IDLE:  sample_ready_c = 1'b1;
            mted_pkg::ST_PREP:  prep_go        = 1'b1;
            mted_pkg::ST_TAPS:  tap_go         = 1'b1;
            mted_pkg::ST_DRAIN: ;
            mted_pkg::ST_FIN:   fin_go         = !mix_valid_reg || mix_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mted_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign sample_ready = sample_ready_c;

    // ------------------------------------------------------------------
    // Input capture, history pointers and tail tracking
    // ------------------------------------------------------------------
    logic signed [mted_pkg::SAMPLE_W-1:0] x_reg;
    logic                                 tail_reg;
    logic [AW-1:0]                        wp_reg;
    logic                                 wrapped_reg;
    logic [mted_pkg::TOTAL_W-1:0]         tail_cnt_reg;
    logic [mted_pkg::TOTAL_W-1:0]         total_reg;
    logic [mted_pkg::TOTAL_W-1:0]         total_raw;
    logic [mted_pkg::TOTAL_W-1:0]         cnt_inc;
    logic                                 done_c;

    // Silence replaces the sample on tail transactions.
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready_c)
        begin
            x_reg    <= sample_data.is_tail ? '0 : sample_data.sample_in;
            tail_reg <= sample_data.is_tail;
        end
    end

    assign total_raw = delay_reg * taps_eff;
    assign cnt_inc   = tail_cnt_reg + mted_pkg::TOTAL_W'(1);

    // A zero-length tail ends on its first tail transaction.
    always_ff @(posedge clk)
    begin
        if (prep_go)
        begin
            total_reg <= (total_raw == '0) ? mted_pkg::TOTAL_W'(1) : total_raw;
        end
    end

    // Beyond its end the tail counter holds and no further flag is raised.
    always_comb
    begin
        done_c = 1'b0;
        if (tail_reg && (tail_cnt_reg < total_reg) && (cnt_inc == total_reg))
        begin
            done_c = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            tail_cnt_reg <= '0;
        end
        else if (fin_go)
        begin
            if (wp_reg == WP_LAST)
            begin
                wp_reg      <= '0;
                wrapped_reg <= 1'b1;
            end
            else
            begin
                wp_reg <= wp_reg + AW'(1);
            end
            if (!tail_reg)
            begin
                tail_cnt_reg <= '0;
            end
            else if (tail_cnt_reg < total_reg)
            begin
                tail_cnt_reg <= cnt_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // History memory
    // ------------------------------------------------------------------
    logic [AW-1:0]                 idx_reg;
    logic [AW-1:0]                 idx_next;
    logic [mted_pkg::SAMPLE_W-1:0] hist_rdata;

    assign idx_next = step_back(idx_reg, dmod_reg);

    // The current sample goes in before any tap is read; a tap that lands on
    // its slot takes the sample from the register instead.
    mted_ram #(
        .WIDTH (mted_pkg::SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (prep_go),
        .waddr (wp_reg),
        .wdata (x_reg),
        .re    (tap_go),
        .raddr (idx_next),
        .rdata (hist_rdata)
    );

    // ------------------------------------------------------------------
    // Tap datapath: power, coefficient, product, accumulate
    // ------------------------------------------------------------------
    logic [mted_pkg::GAIN_W-1:0]          power_reg;
    logic [31:0]                          pow_sum;
    logic [31:0]                          coef_sum;
    logic                                 fwd1_reg;
    logic                                 zero1_reg;
    logic signed [mted_pkg::SAMPLE_W-1:0] h2_reg;
    logic [mted_pkg::GAIN_W-1:0]          coef_reg;
    logic signed [32:0]                   prod_reg;
    logic signed [32:0]                   dry_prod;
    logic signed [ACC_W-1:0]              acc_reg;

    assign pow_sum  = power_reg * fb_eff + mted_pkg::Q15_HALF;
    assign coef_sum = wet_eff * power_reg + mted_pkg::Q15_HALF;
    assign dry_prod = $signed({1'b0, dry_eff}) * x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            tap_left_reg <= '0;
        end
        else
        begin
            v1_reg <= tap_go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (prep_go)
            begin
                tap_left_reg <= taps_eff;
            end
            else if (tap_go)
            begin
                tap_left_reg <= tap_left_reg - mted_pkg::TAPS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prep_go)
        begin
            power_reg <= mted_pkg::Q15_ONE;
            idx_reg   <= wp_reg;
        end
        else if (tap_go)
        begin
            power_reg <= pow_sum[30:15];
            idx_reg   <= idx_next;
        end

        // Entries past the write pointer before the first wrap were never
        // written and read as silence.
        if (tap_go)
        begin
            fwd1_reg  <= (idx_next == wp_reg);
            zero1_reg <= !wrapped_reg && (idx_next > wp_reg);
        end

        if (v1_reg)
        begin
            h2_reg   <= fwd1_reg ? x_reg : (zero1_reg ? '0 : $signed(hist_rdata));
            coef_reg <= coef_sum[30:15];
        end

        if (v2_reg)
        begin
            prod_reg <= $signed({1'b0, coef_reg}) * h2_reg;
        end

        if (prep_go)
        begin
            acc_reg <= {{(ACC_W - 33){dry_prod[32]}}, dry_prod};
        end
        else if (v3_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W - 33){prod_reg[32]}}, prod_reg};
        end
    end

    // ------------------------------------------------------------------
    // Rounding, saturation and output register
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]              rnd_sum;
    logic signed [ACC_W-1:0]              rnd_q;
    logic signed [mted_pkg::SAMPLE_W-1:0] y_c;
    mted_pkg::mix_t                       mix_data_reg;

    assign rnd_sum = acc_reg + ACC_HALF;
    assign rnd_q   = rnd_sum >>> 15;

    always_comb
    begin
        if (rnd_q > SAT_HI)
        begin
            y_c = SAT_HI[mted_pkg::SAMPLE_W-1:0];
        end
        else if (rnd_q < SAT_LO)
        begin
            y_c = SAT_LO[mted_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            y_c = rnd_q[mted_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            mix_valid_reg <= 1'b1;
        end
        else if (mix_ready)
        begin
            mix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            mix_data_reg.sample_out <= y_c;
            mix_data_reg.tail_done  <= done_c;
        end
    end

    assign mix_valid = mix_valid_reg;
    assign mix_data  = mix_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The result is formed only after every tap has been accumulated.
    a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mted_pkg::ST_FIN |-> !(v1_reg || v2_reg || v3_reg))
        else $error("result formed with taps still in flight");

    // The dry term load never collides with an echo accumulate.
    a_acc_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mted_pkg::ST_PREP |-> !v3_reg)
        else $error("dry load collides with tap accumulate");

    // A tap is either the current sample or an older entry, never both.
    a_fwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> !(fwd1_reg && zero1_reg))
        else $error("tap marked both forwarded and unwritten");

    // The circular read index stays inside the history.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mted_pkg::ST_TAPS |-> ({1'b0, idx_reg} < DEPTH_AW1))
        else $error("history index out of range");

    // An accepted transaction goes straight to the preparation cycle.
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> state_reg == mted_pkg::ST_PREP)
        else $error("accepted transaction did not start");

endmodule

`default_nettype wire
